### design/vrs_pkg.sv
`default_nettype none
package vrs_pkg;

   localparam int unsigned COORD_W = 16;
   localparam int unsigned TRIG_W = 17;
   localparam int unsigned PROD_W = COORD_W + TRIG_W;
   localparam int unsigned SUM_W = PROD_W + 1;
   localparam int unsigned CSR_INDEX_W = 8;
   localparam int unsigned CSR_DATA_W = 16;

   localparam logic [CSR_INDEX_W-1:0] REG_ANGLE_X = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_ANGLE_Y = 8'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_ANGLE_Z = 8'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_SCALE = 8'd3;

   localparam logic [15:0] SCALE_RESET = 16'd256;
   localparam longint unsigned PI_HALF_Q30 = 64'd1686629713;

   typedef logic signed [COORD_W-1:0] coord_type;
   typedef logic signed [TRIG_W-1:0] trig_type;

   typedef struct packed {
      coord_type p;
      coord_type q;
      coord_type r;
      logic last;
   } vec_type;

   function automatic logic [14:0] sine_from_x(longint unsigned x);
      longint unsigned term;
      longint sum;
      longint rnd;
      term = x;
      sum = longint'(x);
      for (int k = 1; k <= 7; k++) begin
         term = (term * x) >> 30;
         term = (term * x) >> 30;
         case (k)
            1: term = term / 6;
            2: term = term / 20;
            3: term = term / 42;
            4: term = term / 72;
            5: term = term / 110;
            6: term = term / 156;
            default: term = term / 210;
         endcase
         if ((k % 2) == 1) begin
            sum = sum - longint'(term);
         end else begin
            sum = sum + longint'(term);
         end
      end
      if (sum < 0) begin
         sum = 0;
      end
      rnd = (sum + 32768) >>> 16;
      if (rnd > 16384) begin
         rnd = 16384;
      end
      return rnd[14:0];
   endfunction

   function automatic coord_type sat16(logic signed [SUM_W-1:0] v);
      if (v > $signed(SUM_W'(32767))) begin
         return 16'sh7FFF;
      end else if (v < -$signed(SUM_W'(32768))) begin
         return 16'sh8000;
      end
      return v[COORD_W-1:0];
   endfunction

endpackage
`default_nettype wire

### design/vrs_req_if.sv
`default_nettype none
interface vrs_req_if;
   logic valid;
   logic ready;
   logic signed [15:0] point_x;
   logic signed [15:0] point_y;
   logic signed [15:0] point_z;
   logic last_point;
   modport source (output valid, point_x, point_y, point_z, last_point, input ready);
   modport sink (input valid, point_x, point_y, point_z, last_point, output ready);
endinterface
`default_nettype wire

### design/vrs_rsp_if.sv
`default_nettype none
interface vrs_rsp_if;
   logic valid;
   logic ready;
   logic signed [15:0] out_x;
   logic signed [15:0] out_y;
   logic signed [15:0] out_z;
   logic out_last;
   modport source (output valid, out_x, out_y, out_z, out_last, input ready);
   modport sink (input valid, out_x, out_y, out_z, out_last, output ready);
endinterface
`default_nettype wire

### design/vertex_rotate_xyz_scale.sv
// Rotates a stream of signed Q8.8 vertices about X, then Y, then Z, and applies a
// uniform Q8.8 scale.
// The req channel carries one vertex per word with its last flag; the rsp channel
// returns the transformed vertex with the flag copied.
// The csr port writes the three binary angles and the scale. Sine and cosine are
// looked up from the quarter-wave table when a register is written.
// Each rotation cell registers products, then sum and saturation; the scale cell
// registers the scaled vertex and also holds the output word.
// Throughput is one word per cycle while rsp is not stalled. Every stage has its own
// valid bit, so a new word is taken whenever the first stage is free or moving on.
// When the receiver stalls, the rsp word holds and the cells fill up behind it;
// req.ready falls only once all seven stages are full.
// Reset empties the pipeline, clears the angles and sets the scale to one.
`default_nettype none
module vertex_rotate_xyz_scale #(
   parameter int unsigned SINE_TABLE_DEPTH = 256
) (
   input wire logic clock,
   input wire logic reset,
   vrs_req_if.sink req,
   vrs_rsp_if.source rsp,
   input wire logic csr_we,
   input wire logic [vrs_pkg::CSR_INDEX_W-1:0] csr_index,
   input wire logic [vrs_pkg::CSR_DATA_W-1:0] csr_data
);

   localparam int unsigned IW = $clog2(SINE_TABLE_DEPTH + 1);
   localparam int unsigned KW = 14 + IW;

   logic [14:0] sine_rom [0:SINE_TABLE_DEPTH];

   for (genvar i = 0; i <= SINE_TABLE_DEPTH; i++) begin : g_rom
      localparam longint unsigned XQ = (vrs_pkg::PI_HALF_Q30 * i) / SINE_TABLE_DEPTH;
      assign sine_rom[i] = vrs_pkg::sine_from_x(XQ);
   end

   function automatic vrs_pkg::trig_type lookup(logic [15:0] a, logic [14:0] rom_k,
                                                logic [14:0] rom_m);
      logic [14:0] mag;
      mag = a[14] ? rom_m : rom_k;
      return a[15] ? -$signed({2'b00, mag}) : $signed({2'b00, mag});
   endfunction

   logic [15:0] ang_sin, ang_cos;
   logic [KW-1:0] k_sin, k_cos;
   logic [IW-1:0] ks, kc;
   logic [IW-1:0] ks_m, kc_m;
   vrs_pkg::trig_type wr_sin, wr_cos;

   always_comb begin
      ang_sin = csr_data;
      ang_cos = csr_data + 16'd16384;
      k_sin = (KW'(ang_sin[13:0]) * KW'(SINE_TABLE_DEPTH)) >> 14;
      k_cos = (KW'(ang_cos[13:0]) * KW'(SINE_TABLE_DEPTH)) >> 14;
      ks = k_sin[IW-1:0];
      kc = k_cos[IW-1:0];
      ks_m = IW'(SINE_TABLE_DEPTH) - ks;
      kc_m = IW'(SINE_TABLE_DEPTH) - kc;
      wr_sin = lookup(ang_sin, sine_rom[ks], sine_rom[ks_m]);
      wr_cos = lookup(ang_cos, sine_rom[kc], sine_rom[kc_m]);
   end

   vrs_pkg::trig_type sin_x_ff, cos_x_ff, sin_y_ff, cos_y_ff, sin_z_ff, cos_z_ff;
   logic [15:0] scale_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sin_x_ff <= $signed({2'b00, sine_rom[0]});
         cos_x_ff <= $signed({2'b00, sine_rom[SINE_TABLE_DEPTH]});
         sin_y_ff <= $signed({2'b00, sine_rom[0]});
         cos_y_ff <= $signed({2'b00, sine_rom[SINE_TABLE_DEPTH]});
         sin_z_ff <= $signed({2'b00, sine_rom[0]});
         cos_z_ff <= $signed({2'b00, sine_rom[SINE_TABLE_DEPTH]});
         scale_ff <= vrs_pkg::SCALE_RESET;
      end else if (csr_we) begin
         case (csr_index)
            vrs_pkg::REG_ANGLE_X: begin
               sin_x_ff <= wr_sin;
               cos_x_ff <= wr_cos;
            end
            vrs_pkg::REG_ANGLE_Y: begin
               sin_y_ff <= wr_sin;
               cos_y_ff <= wr_cos;
            end
            vrs_pkg::REG_ANGLE_Z: begin
               sin_z_ff <= wr_sin;
               cos_z_ff <= wr_cos;
            end
            vrs_pkg::REG_SCALE: begin
               scale_ff <= csr_data;
            end
            default: begin
            end
         endcase
      end
   end

   vrs_pkg::vec_type in_x_vec, out_x_vec, in_y_vec, out_y_vec, in_z_vec, out_z_vec;
   logic vx, vy, vz, ry, rz, rs;

   always_comb begin
      in_x_vec.p = req.point_y;
      in_x_vec.q = req.point_z;
      in_x_vec.r = req.point_x;
      in_x_vec.last = req.last_point;
      in_y_vec.p = out_x_vec.r;
      in_y_vec.q = out_x_vec.q;
      in_y_vec.r = out_x_vec.p;
      in_y_vec.last = out_x_vec.last;
      in_z_vec.p = out_y_vec.r;
      in_z_vec.q = out_y_vec.p;
      in_z_vec.r = out_y_vec.q;
      in_z_vec.last = out_y_vec.last;
   end

   vrs_rot_cell u_rot_x (
      .clock(clock), .reset(reset),
      .in_valid(req.valid), .in_ready(req.ready), .in_data(in_x_vec),
      .sin_val(sin_x_ff), .cos_val(cos_x_ff),
      .out_valid(vx), .out_ready(ry), .out_data(out_x_vec)
   );

   vrs_rot_cell u_rot_y (
      .clock(clock), .reset(reset),
      .in_valid(vx), .in_ready(ry), .in_data(in_y_vec),
      .sin_val(sin_y_ff), .cos_val(cos_y_ff),
      .out_valid(vy), .out_ready(rz), .out_data(out_y_vec)
   );

   vrs_rot_cell u_rot_z (
      .clock(clock), .reset(reset),
      .in_valid(vy), .in_ready(rz), .in_data(in_z_vec),
      .sin_val(sin_z_ff), .cos_val(cos_z_ff),
      .out_valid(vz), .out_ready(rs), .out_data(out_z_vec)
   );

   vrs_scale_cell u_scale (
      .clock(clock), .reset(reset),
      .in_valid(vz), .in_ready(rs),
      .in_x(out_z_vec.q), .in_y(out_z_vec.p), .in_z(out_z_vec.r),
      .in_last(out_z_vec.last), .scale(scale_ff), .rsp(rsp)
   );

endmodule
`default_nettype wire

### design/vrs_rot_cell.sv
`default_nettype none
module vrs_rot_cell (
   input wire logic clock,
   input wire logic reset,
   input wire logic in_valid,
   output logic in_ready,
   input wire vrs_pkg::vec_type in_data,
   input wire vrs_pkg::trig_type sin_val,
   input wire vrs_pkg::trig_type cos_val,
   output logic out_valid,
   input wire logic out_ready,
   output vrs_pkg::vec_type out_data
);

   logic v1_ff;
   logic v2_ff;
   logic adv1;
   logic adv2;
   logic signed [vrs_pkg::PROD_W-1:0] pc_ff, ps_ff, qc_ff, qs_ff;
   vrs_pkg::coord_type r1_ff;
   logic last1_ff;
   vrs_pkg::vec_type out_ff;
   logic signed [vrs_pkg::SUM_W-1:0] np_sum, nq_sum;

   assign adv2 = !v2_ff || out_ready;
   assign adv1 = !v1_ff || adv2;
   assign in_ready = adv1;
   assign out_valid = v2_ff;
   assign out_data = out_ff;

   always_comb begin
      np_sum = vrs_pkg::SUM_W'(pc_ff) - vrs_pkg::SUM_W'(qs_ff) + vrs_pkg::SUM_W'(8192);
      nq_sum = vrs_pkg::SUM_W'(qc_ff) + vrs_pkg::SUM_W'(ps_ff) + vrs_pkg::SUM_W'(8192);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         if (adv1) begin
            v1_ff <= in_valid;
         end
         if (adv2) begin
            v2_ff <= v1_ff;
         end
      end
      if (adv1) begin
         pc_ff <= in_data.p * cos_val;
         ps_ff <= in_data.p * sin_val;
         qc_ff <= in_data.q * cos_val;
         qs_ff <= in_data.q * sin_val;
         r1_ff <= in_data.r;
         last1_ff <= in_data.last;
      end
      if (adv2) begin
         out_ff.p <= vrs_pkg::sat16(np_sum >>> 14);
         out_ff.q <= vrs_pkg::sat16(nq_sum >>> 14);
         out_ff.r <= r1_ff;
         out_ff.last <= last1_ff;
      end
   end

endmodule
`default_nettype wire

### design/vrs_scale_cell.sv
`default_nettype none
module vrs_scale_cell (
   input wire logic clock,
   input wire logic reset,
   input wire logic in_valid,
   output logic in_ready,
   input wire vrs_pkg::coord_type in_x,
   input wire vrs_pkg::coord_type in_y,
   input wire vrs_pkg::coord_type in_z,
   input wire logic in_last,
   input wire logic [15:0] scale,
   vrs_rsp_if.source rsp
);

   logic valid_ff;
   logic adv;
   logic signed [vrs_pkg::SUM_W-1:0] sx, sy, sz, sf;

   assign adv = !valid_ff || rsp.ready;
   assign in_ready = adv;
   assign rsp.valid = valid_ff;

   always_comb begin
      sf = $signed({{(vrs_pkg::SUM_W-16){1'b0}}, scale});
      sx = vrs_pkg::SUM_W'(in_x) * sf + vrs_pkg::SUM_W'(128);
      sy = vrs_pkg::SUM_W'(in_y) * sf + vrs_pkg::SUM_W'(128);
      sz = vrs_pkg::SUM_W'(in_z) * sf + vrs_pkg::SUM_W'(128);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= in_valid;
      end
      if (adv) begin
         rsp.out_x <= vrs_pkg::sat16(sx >>> 8);
         rsp.out_y <= vrs_pkg::sat16(sy >>> 8);
         rsp.out_z <= vrs_pkg::sat16(sz >>> 8);
         rsp.out_last <= in_last;
      end
   end

endmodule
`default_nettype wire

### design/vrs_checker.sv
`default_nettype none
module vrs_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   input wire logic req_ready,
   input wire logic rsp_valid,
   input wire logic rsp_ready,
   input wire logic [15:0] rsp_out_x,
   input wire logic rsp_out_last
);

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp valid right after reset");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_x) && $stable(rsp_out_last))
      else $error("stalled rsp word changed");

   a_full_only: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("req not ready while output is free");

   a_first_latency: assert property (@(posedge clock)
      reset |=> !rsp_valid ##1 !rsp_valid)
      else $error("word out too soon after reset");

endmodule

bind vertex_rotate_xyz_scale vrs_checker u_vrs_checker (
   .clock(clock), .reset(reset),
   .req_valid(req.valid), .req_ready(req.ready),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
   .rsp_out_x(rsp.out_x), .rsp_out_last(rsp.out_last)
);
`default_nettype wire
